>>> rtl/plar_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plar_pkg
// Shared types, constants and tables of the polyline arc length resampler.
// ----------------------------------------------------------------------------
package plar_pkg;

    // Largest number of points one segment may produce.
    localparam int MAX_PTS = 64;
    localparam int CNT_W   = $clog2(MAX_PTS + 1);

    // Spacing after reset, unsigned Q15.16.
    localparam logic [30:0] SPACING_RST = 31'd65536;

    // Angles: CORDIC works in 2^24 units per turn; outputs use 2^16.
    localparam int           CORDIC_STEPS = 18;
    localparam logic [23:0]  ANG_HALF     = 24'h800000;
    localparam logic [23:0]  ANG_ROUND    = 24'd128;
    localparam logic [15:0]  QUARTER_TURN = 16'd16384;

    // Command queue between front and back.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic {
        K_START,
        K_SEG
    } t_kind;

    // One command from the front: a path start vertex or a closed segment.
    // For a start, a and b hold the vertex; for a segment, dx and dy.
    typedef struct packed {
        t_kind              kind;
        logic signed [32:0] a;
        logic signed [32:0] b;
        logic [32:0]        len;
        logic [15:0]        head;
        logic [31:0]        curv;
        logic [3:0]         cls;
    } t_cmd;

    // One result point.
    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] head;
        logic [15:0] normal;
        logic [31:0] curv;
        logic [3:0]  cls;
        logic        last;
        logic        ovf;
    } t_res;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [2:0] {
        F_IDLE,
        F_SQA,
        F_SQB,
        F_SQRT,
        F_NORM,
        F_CORD,
        F_PUSH
    } t_front_state;

    typedef enum logic [3:0] {
        B_IDLE,
        B_START,
        B_SETUP,
        B_MUL,
        B_PREP,
        B_DIV,
        B_SAT,
        B_EMIT
    } t_back_state;

    // Arctangent of 2^-i in 2^24 units per turn.
    function automatic logic [23:0] atan_lut(input logic [4:0] idx);
        logic [23:0] v;
        unique case (idx)
            5'd0:    v = 24'd2097152;
            5'd1:    v = 24'd1238021;
            5'd2:    v = 24'd654136;
            5'd3:    v = 24'd332050;
            5'd4:    v = 24'd166669;
            5'd5:    v = 24'd83416;
            5'd6:    v = 24'd41718;
            5'd7:    v = 24'd20860;
            5'd8:    v = 24'd10430;
            5'd9:    v = 24'd5215;
            5'd10:   v = 24'd2608;
            5'd11:   v = 24'd1304;
            5'd12:   v = 24'd652;
            5'd13:   v = 24'd326;
            5'd14:   v = 24'd163;
            5'd15:   v = 24'd81;
            5'd16:   v = 24'd41;
            5'd17:   v = 24'd20;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/plar_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plar_front
// Accepts vertices, classifies them and works out each segment's length
// (bit-serial square root) and heading (normalise, then 18-step CORDIC).
// ----------------------------------------------------------------------------
module plar_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [31:0]          i_px,
    input  logic [31:0]          i_py,
    input  logic [15:0]          i_hd,
    input  logic [31:0]          i_cv,
    input  logic [3:0]           i_cls,
    input  logic                 i_start,
    output logic                 o_push,
    output plar_pkg::t_cmd       o_cmd,
    input  plar_pkg::t_q_stat    i_qstat
);
    import plar_pkg::*;

    t_front_state r_state, n_state;

    logic               r_started;
    logic [31:0]        r_prev_x, r_prev_y;
    logic [3:0]         r_prev_cls;
    t_cmd               r_cmd;
    logic [65:0]        r_rad;
    logic [35:0]        r_rem;
    logic [32:0]        r_root;
    logic [5:0]         r_cnt;
    logic signed [44:0] r_cx, r_cy;
    logic [40:0]        r_m;
    logic [23:0]        r_z;
    logic [4:0]         r_i;

    logic               w_acc;
    logic signed [32:0] w_dx, w_dy;
    logic [32:0]        w_ax_full, w_ay_full;
    logic [31:0]        w_mag;
    logic [63:0]        w_sq;
    logic [35:0]        w_rem2, w_trial;
    logic signed [44:0] w_xs, w_ys;
    logic [23:0]        w_zr;

    assign o_ready = (r_state == F_IDLE);
    assign w_acc   = i_valid && o_ready;
    assign o_push  = (r_state == F_PUSH) && !i_qstat.full;

    // The command handed to the queue carries the rounded CORDIC angle for a segment.
    always_comb begin
        o_cmd = r_cmd;
        if (r_cmd.kind == K_SEG) begin
            o_cmd.head = w_zr[23:8];
        end
    end

    // Segment deltas against the previous vertex, and magnitudes.
    assign w_dx      = $signed({i_px[31], i_px}) - $signed({r_prev_x[31], r_prev_x});
    assign w_dy      = $signed({i_py[31], i_py}) - $signed({r_prev_y[31], r_prev_y});
    assign w_ax_full = r_cmd.a[32] ? 33'(-r_cmd.a) : 33'(r_cmd.a);
    assign w_ay_full = r_cmd.b[32] ? 33'(-r_cmd.b) : 33'(r_cmd.b);

    // One shared squarer for both axes.
    assign w_mag = (r_state == F_SQA) ? w_ax_full[31:0] : w_ay_full[31:0];
    assign w_sq  = w_mag * w_mag;

    // Square root step: bring down two radicand bits, try the next root bit.
    assign w_rem2  = {r_rem[33:0], r_rad[65:64]};
    assign w_trial = {1'b0, r_root, 2'b01};

    // CORDIC vectoring step.
    assign w_xs = r_cx >>> r_i;
    assign w_ys = r_cy >>> r_i;
    assign w_zr = r_z + ANG_ROUND;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (w_acc) begin
                    if (i_start || !r_started) begin
                        n_state = F_PUSH;
                    end else if (w_dx != '0 || w_dy != '0) begin
                        n_state = F_SQA;
                    end
                end
            end
            F_SQA:  n_state = F_SQB;
            F_SQB:  n_state = F_SQRT;
            F_SQRT: if (r_cnt == '0) n_state = F_NORM;
            F_NORM: if (r_m[40]) n_state = F_CORD;
            F_CORD: if (r_i == 5'(CORDIC_STEPS - 1)) n_state = F_PUSH;
            F_PUSH: if (!i_qstat.full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= F_IDLE;
            r_started  <= 1'b0;
            r_prev_x   <= '0;
            r_prev_y   <= '0;
            r_prev_cls <= '0;
        end else begin
            r_state <= n_state;
            // Vertex intake: path start or a new segment.
            if (w_acc) begin
                r_prev_x   <= i_px;
                r_prev_y   <= i_py;
                r_prev_cls <= i_cls;
                r_started  <= 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            F_IDLE: begin
                if (w_acc) begin
                    if (i_start || !r_started) begin
                        r_cmd.kind <= K_START;
                        r_cmd.a    <= $signed({i_px[31], i_px});
                        r_cmd.b    <= $signed({i_py[31], i_py});
                        r_cmd.len  <= '0;
                        r_cmd.head <= i_hd;
                        r_cmd.curv <= i_cv;
                        r_cmd.cls  <= i_cls;
                    end else begin
                        r_cmd.kind <= K_SEG;
                        r_cmd.a    <= w_dx;
                        r_cmd.b    <= w_dy;
                        r_cmd.curv <= '0;
                        r_cmd.cls  <= r_prev_cls;
                    end
                end
            end
            F_SQA: begin
                r_rad <= {2'b00, w_sq};
            end
            F_SQB: begin
                r_rad  <= r_rad + {2'b00, w_sq};
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= 6'd32;
            end
            F_SQRT: begin
                r_rad <= {r_rad[63:0], 2'b00};
                r_cnt <= r_cnt - 6'd1;
                if (w_rem2 >= w_trial) begin
                    r_rem  <= w_rem2 - w_trial;
                    r_root <= {r_root[31:0], 1'b1};
                end else begin
                    r_rem  <= w_rem2;
                    r_root <= {r_root[31:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    r_cx <= 45'(r_cmd.a);
                    r_cy <= 45'(r_cmd.b);
                    r_m  <= (w_ax_full > w_ay_full) ? 41'(w_ax_full) : 41'(w_ay_full);
                end
            end
            F_NORM: begin
                r_cmd.len <= r_root;
                // Scale up until the larger magnitude reaches 2^40.
                if (!r_m[40]) begin
                    r_cx <= r_cx <<< 1;
                    r_cy <= r_cy <<< 1;
                    r_m  <= r_m << 1;
                end else begin
                    r_i <= '0;
                    if (r_cx < 0) begin
                        r_cx <= -r_cx;
                        r_cy <= -r_cy;
                        r_z  <= ANG_HALF;
                    end else begin
                        r_z <= '0;
                    end
                end
            end
            F_CORD: begin
                r_i <= r_i + 5'd1;
                if (r_cy >= 0) begin
                    r_cx <= r_cx + w_ys;
                    r_cy <= r_cy - w_xs;
                    r_z  <= r_z + atan_lut(r_i);
                end else begin
                    r_cx <= r_cx - w_ys;
                    r_cy <= r_cy + w_xs;
                    r_z  <= r_z - atan_lut(r_i);
                end
            end
            default: begin
            end
        endcase
    end

endmodule

>>> rtl/plar_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plar_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module plar_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  plar_pkg::t_cmd     i_data,
    input  logic               i_pop,
    output plar_pkg::t_cmd     o_data,
    output plar_pkg::t_q_stat  o_stat
);
    import plar_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               w_do_push, w_do_pop;

    assign o_stat.full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign w_do_push    = i_push && !o_stat.full;
    assign w_do_pop     = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rd];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) r_wr <= (r_wr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (w_do_pop)  r_rd <= (r_rd == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            if (w_do_push && !w_do_pop) r_cnt <= r_cnt + 1'b1;
            else if (!w_do_push && w_do_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_do_push) r_mem[r_wr] <= i_data;
    end

endmodule

>>> rtl/plar_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plar_back
// Carries out queued commands: walks each segment by the spacing, places
// every point with a multiply and a bit-serial divide per axis, and holds
// the result in an output register.
// ----------------------------------------------------------------------------
module plar_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [30:0]        i_cfg_wdata,
    input  plar_pkg::t_cmd     i_cmd,
    input  plar_pkg::t_q_stat  i_qstat,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output plar_pkg::t_res     o_res
);
    import plar_pkg::*;

    t_back_state r_state, n_state;

    logic [30:0]        r_spacing;
    logic [31:0]        r_emit_x, r_emit_y;
    logic [30:0]        r_carry;
    t_cmd               r_cmd;
    logic [30:0]        r_ds;
    logic [30:0]        r_offset;
    logic [32:0]        r_remain;
    logic               r_ovf;
    logic [CNT_W-1:0]   r_n;
    logic               r_sel;
    logic [63:0]        r_prod;
    logic [33:0]        r_rem;
    logic [31:0]        r_lo;
    logic [4:0]         r_dcnt;
    logic [31:0]        r_new_x, r_new_y;
    logic               r_out_valid;
    t_res               r_out;

    logic [30:0]        w_ds, w_acc;
    logic [33:0]        w_sum;
    logic [37:0]        w_lim;
    logic [32:0]        w_mag_full;
    logic [63:0]        w_div;
    logic [33:0]        w_r2;
    logic               w_qbit;
    logic [31:0]        w_base;
    logic               w_neg;
    logic signed [33:0] w_sat_sum;
    logic [31:0]        w_sat;
    logic [32:0]        w_rem_next;
    logic               w_last;
    logic               w_space;
    logic               w_load;

    assign o_valid = r_out_valid;
    assign o_res   = r_out;
    assign o_pop   = (r_state == B_IDLE) && !i_qstat.empty;
    assign w_space = !r_out_valid || i_ready;
    assign w_load  = w_space && ((r_state == B_START) || (r_state == B_EMIT));

    // Segment setup: effective spacing, clamped carry, overflow test.
    assign w_ds  = (r_spacing == '0) ? 31'd1 : r_spacing;
    assign w_acc = (r_carry > w_ds) ? w_ds : r_carry;
    assign w_sum = 34'(w_acc) + 34'(r_cmd.len);
    assign w_lim = 38'(w_ds) * 38'(MAX_PTS + 1);

    // Multiply and divide for one axis.
    assign w_mag_full = r_sel ? (r_cmd.b[32] ? 33'(-r_cmd.b) : 33'(r_cmd.b))
                              : (r_cmd.a[32] ? 33'(-r_cmd.a) : 33'(r_cmd.a));
    assign w_div  = r_prod + 64'(r_cmd.len[32:1]);
    assign w_r2   = {r_rem[32:0], r_lo[31]};
    assign w_qbit = (w_r2 >= {1'b0, r_cmd.len});

    // Step from the last emitted point, saturating to 32 bits.
    assign w_base    = r_sel ? r_emit_y : r_emit_x;
    assign w_neg     = r_sel ? r_cmd.b[32] : r_cmd.a[32];
    assign w_sat_sum = w_neg ? $signed({{2{w_base[31]}}, w_base}) - $signed({2'b00, r_lo})
                             : $signed({{2{w_base[31]}}, w_base}) + $signed({2'b00, r_lo});
    always_comb begin
        if (w_sat_sum > $signed(34'h0_7FFF_FFFF))       w_sat = 32'h7FFF_FFFF;
        else if (w_sat_sum < $signed(34'h3_8000_0000))  w_sat = 32'h8000_0000;
        else                                            w_sat = w_sat_sum[31:0];
    end

    // Bookkeeping after a point is handed over.
    assign w_rem_next = r_remain - 33'(r_offset);
    assign w_last     = (r_n == CNT_W'(MAX_PTS - 1)) || (w_rem_next < 33'(r_ds));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (!i_qstat.empty) n_state = (i_cmd.kind == K_START) ? B_START : B_SETUP;
            end
            B_START: if (w_space) n_state = B_IDLE;
            B_SETUP: n_state = (w_sum < 34'(w_ds)) ? B_IDLE : B_MUL;
            B_MUL:   n_state = B_PREP;
            B_PREP:  n_state = B_DIV;
            B_DIV:   if (r_dcnt == 5'd31) n_state = B_SAT;
            B_SAT:   n_state = r_sel ? B_EMIT : B_MUL;
            B_EMIT:  if (w_space) n_state = w_last ? B_IDLE : B_MUL;
            default: n_state = B_IDLE;
        endcase
    end

    // Control state, configuration and carried path state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_spacing   <= SPACING_RST;
            r_emit_x    <= '0;
            r_emit_y    <= '0;
            r_carry     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_spacing <= i_cfg_wdata;
            if (w_load) r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                B_START: begin
                    if (w_space) begin
                        r_emit_x <= r_cmd.a[31:0];
                        r_emit_y <= r_cmd.b[31:0];
                        r_carry  <= '0;
                    end
                end
                B_SETUP: begin
                    if (w_sum < 34'(w_ds)) r_carry <= w_sum[30:0];
                end
                B_SAT: begin
                    if (r_sel) begin
                        r_emit_x <= r_new_x;
                        r_emit_y <= w_sat;
                    end
                end
                B_EMIT: begin
                    if (w_space && w_last) r_carry <= r_ovf ? '0 : w_rem_next[30:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                if (!i_qstat.empty) r_cmd <= i_cmd;
            end
            B_SETUP: begin
                r_ds     <= w_ds;
                r_offset <= w_ds - w_acc;
                r_remain <= r_cmd.len;
                r_ovf    <= ({4'b0000, w_sum} >= w_lim);
                r_n      <= '0;
                r_sel    <= 1'b0;
            end
            B_MUL: begin
                r_prod <= w_mag_full[31:0] * {1'b0, r_offset};
            end
            B_PREP: begin
                r_rem  <= {2'b00, w_div[63:32]};
                r_lo   <= w_div[31:0];
                r_dcnt <= '0;
            end
            B_DIV: begin
                r_dcnt <= r_dcnt + 5'd1;
                r_rem  <= w_qbit ? (w_r2 - {1'b0, r_cmd.len}) : w_r2;
                r_lo   <= {r_lo[30:0], w_qbit};
            end
            B_SAT: begin
                if (r_sel) begin
                    r_new_y <= w_sat;
                end else begin
                    r_new_x <= w_sat;
                    r_sel   <= 1'b1;
                end
            end
            B_EMIT: begin
                if (w_space) begin
                    r_remain <= w_rem_next;
                    r_offset <= r_ds;
                    r_n      <= r_n + 1'b1;
                    r_sel    <= 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.head   <= r_cmd.head;
            r_out.normal <= r_cmd.head + QUARTER_TURN;
            r_out.curv   <= r_cmd.curv;
            r_out.cls    <= r_cmd.cls;
            if (r_state == B_START) begin
                r_out.x    <= r_cmd.a[31:0];
                r_out.y    <= r_cmd.b[31:0];
                r_out.last <= 1'b1;
                r_out.ovf  <= 1'b0;
            end else begin
                r_out.x    <= r_new_x;
                r_out.y    <= r_new_y;
                r_out.last <= w_last;
                r_out.ovf  <= r_ovf;
            end
        end
    end

endmodule

>>> rtl/polyline_arc_length_resampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_arc_length_resampler
// Resamples a stream of polyline vertices into points a fixed distance apart.
// ----------------------------------------------------------------------------
// Vertices arrive on the s_axis channel, one request each; path_start rides
// in tuser.  Resampled points leave on m_axis; tlast marks the final point a
// vertex causes and tuser flags a segment cut at 64 points.  Spacing is set
// through i_cfg_we / i_cfg_wdata while the block is idle; the user must keep
// to this, as the block does not enforce it.  The front takes one vertex and
// no other until done with it: for a new segment it squares both axes, runs
// a 33-step square root, a normalising shift, a CORDIC setup step and an
// 18-step CORDIC, then hands over to the queue, waiting while it is full.
// A path start vertex goes straight to the hand-over; a zero-length segment
// is dropped.  For each point the back runs a multiply and a 32-step serial
// divide once per axis, then loads the output register; each segment is
// first set up.  A two-entry command queue lets the front work on the next
// segment while the back is still placing points.  Reset clears the queue,
// the output valid flag and all path state and restores the spacing to 1.0.
// When the receiver holds tready low the output register keeps its point,
// the back stalls, then the queue fills and finally s_axis tready falls.
// ----------------------------------------------------------------------------
module polyline_arc_length_resampler (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [30:0]  i_cfg_wdata,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // point_x, point_y, point_heading, point_curvature, point_class, 4'b0
    input  logic [119:0] i_s_axis_tdata,
    // path_start
    input  logic         i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // out_x, out_y, out_heading, out_normal, out_curvature, out_class, 4'b0
    output logic [135:0] o_m_axis_tdata,
    output logic         o_m_axis_tlast,
    // out_overflow
    output logic         o_m_axis_tuser
);
    import plar_pkg::*;

    t_cmd    w_push_cmd, w_head_cmd;
    logic    w_push, w_pop;
    t_q_stat w_qstat;
    t_res    w_res;

    plar_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_px    (i_s_axis_tdata[31:0]),
        .i_py    (i_s_axis_tdata[63:32]),
        .i_hd    (i_s_axis_tdata[79:64]),
        .i_cv    (i_s_axis_tdata[111:80]),
        .i_cls   (i_s_axis_tdata[115:112]),
        .i_start (i_s_axis_tuser),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd),
        .i_qstat (w_qstat)
    );

    plar_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cmd),
        .i_pop   (w_pop),
        .o_data  (w_head_cmd),
        .o_stat  (w_qstat)
    );

    plar_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_head_cmd),
        .i_qstat     (w_qstat),
        .o_pop       (w_pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_res       (w_res)
    );

    // Pack the result point onto the stream.
    assign o_m_axis_tdata = {4'b0000, w_res.cls, w_res.curv, w_res.normal,
                             w_res.head, w_res.y, w_res.x};
    assign o_m_axis_tlast = w_res.last;
    assign o_m_axis_tuser = w_res.ovf;

endmodule

>>> rtl/plar_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plar_checker
// Port-level checks on the resampler's output stream.
// ----------------------------------------------------------------------------
module plar_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_m_tvalid,
    input logic         i_m_tready,
    input logic [135:0] i_m_tdata,
    input logic         i_m_tlast,
    input logic         i_m_tuser
);

    // A stalled request keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata)
            && $stable(i_m_tlast) && $stable(i_m_tuser))
        else $error("output request changed while stalled");

    // The normal is always a quarter turn past the heading.
    a_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> i_m_tdata[95:80] == 16'(i_m_tdata[79:64] + 16'd16384))
        else $error("normal does not follow heading");

    // A cut segment only produces interpolated points, which have no curvature.
    a_ovf_curv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser |-> i_m_tdata[127:96] == 32'd0)
        else $error("overflow point carries curvature");

    // Nothing is offered straight after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("output valid after reset");

endmodule

bind polyline_arc_length_resampler plar_checker u_plar_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tlast  (o_m_axis_tlast),
    .i_m_tuser  (o_m_axis_tuser)
);

>>> test/tb_polyline_arc_length_resampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polyline_arc_length_resampler
// Self-checking bench for the resampler. A behavioural predictor turns every
// accepted vertex into the points it should cause, and a checker process
// compares each point on the output stream against them in order.
// ----------------------------------------------------------------------------
module tb_polyline_arc_length_resampler;
    import plar_pkg::*;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] head;
        logic [15:0] normal;
        logic [31:0] curv;
        logic [3:0]  cls;
        logic        last;
        logic        ovf;
    } t_point;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [30:0]  i_cfg_wdata;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [119:0] i_s_axis_tdata;
    logic         i_s_axis_tuser;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [135:0] o_m_axis_tdata;
    logic         o_m_axis_tlast;
    logic         o_m_axis_tuser;

    // Predictor state.
    logic [30:0]        pr_spacing;
    logic signed [31:0] pr_prev_x, pr_prev_y, pr_emit_x, pr_emit_y;
    logic [3:0]         pr_prev_cls;
    logic [31:0]        pr_carry;
    logic               pr_started;

    t_point pending_points[$];
    int     error_count;
    int     hold_cycles;
    bit     sink_random;

    polyline_arc_length_resampler u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Bit-serial integer square root of a 65-bit sum of squares.
    function automatic logic [63:0] isqrt(input logic [63:0] ax, input logic [63:0] ay);
        logic [127:0] sq;
        logic [63:0]  root;
        logic [67:0]  rem, trial;
        sq = ax * ax + ay * ay;
        root = 0;
        rem = 0;
        for (int i = 32; i >= 0; i--) begin
            rem = (rem << 2) | ((sq >> (2 * i)) & 2'd3);
            trial = (root << 2) | 1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    // Arctangent by 18 rotation steps, angles in 2^24 per turn.
    function automatic logic [15:0] seg_heading(input longint dx, input longint dy);
        longint x, y, xs, ys;
        longint unsigned m, ax, ay;
        logic [23:0] z;
        x = dx;
        y = dy;
        z = 0;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        m = ax > ay ? ax : ay;
        while (m < (64'd1 << 40)) begin
            x = x * 2;
            y = y * 2;
            m = m << 1;
        end
        if (x < 0) begin
            x = -x;
            y = -y;
            z = ANG_HALF;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_lut(i[4:0]);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - atan_lut(i[4:0]);
            end
        end
        z = z + ANG_ROUND;
        return z[23:8];
    endfunction

    // One step along a segment, rounded half away from zero and saturated.
    function automatic logic signed [31:0] step_along(input logic signed [31:0] base,
            input longint d, input longint unsigned offset, input longint unsigned len);
        logic [127:0] prod;
        longint       q, r;
        prod = (d < 0 ? -d : d);
        prod = (prod * offset + len / 2) / len;
        q = prod[63:0];
        r = longint'(base) + (d < 0 ? -q : q);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    // Work out the points that one accepted vertex causes.
    task automatic predict_vertex(input logic [119:0] data, input logic start);
        logic signed [31:0] px, py;
        logic [15:0] hd, head;
        logic [31:0] cv;
        logic [3:0]  cls, seg_cls;
        longint dx, dy;
        longint unsigned len, ds, acc, remain, offset;
        int n;
        bit ovf;
        t_point p, seg_pts[$];
        px = data[31:0];
        py = data[63:32];
        hd = data[79:64];
        cv = data[111:80];
        cls = data[115:112];
        if (start || !pr_started) begin
            p = '{px, py, hd, hd + QUARTER_TURN, cv, cls, 1'b1, 1'b0};
            pending_points = {pending_points, p};
            pr_prev_x = px; pr_emit_x = px;
            pr_prev_y = py; pr_emit_y = py;
            pr_prev_cls = cls;
            pr_carry = 0;
            pr_started = 1'b1;
            return;
        end
        dx = longint'(px) - longint'(pr_prev_x);
        dy = longint'(py) - longint'(pr_prev_y);
        seg_cls = pr_prev_cls;
        pr_prev_x = px;
        pr_prev_y = py;
        pr_prev_cls = cls;
        if (dx == 0 && dy == 0) return;
        len = isqrt(dx < 0 ? -dx : dx, dy < 0 ? -dy : dy);
        head = seg_heading(dx, dy);
        ds = pr_spacing == 0 ? 1 : pr_spacing;
        acc = pr_carry > ds ? ds : pr_carry;
        remain = len;
        n = 0;
        ovf = 0;
        while (acc + remain >= ds) begin
            if (n >= MAX_PTS) begin
                ovf = 1;
                break;
            end
            offset = ds - acc;
            pr_emit_x = step_along(pr_emit_x, dx, offset, len);
            pr_emit_y = step_along(pr_emit_y, dy, offset, len);
            p = '{pr_emit_x, pr_emit_y, head, head + QUARTER_TURN, 32'd0, seg_cls,
                  1'b0, 1'b0};
            seg_pts = {seg_pts, p};
            n++;
            remain = remain - offset;
            acc = 0;
        end
        pr_carry = ovf ? 0 : 32'(acc + remain);
        foreach (seg_pts[k]) begin
            seg_pts[k].ovf = ovf;
            if (k == n - 1) seg_pts[k].last = 1'b1;
            pending_points = {pending_points, seg_pts[k]};
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
            input logic [63:0] want);
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Send one vertex after a random gap; the request stays up until accepted.
    task automatic send_vertex(input logic signed [31:0] x, input logic signed [31:0] y,
            input logic [15:0] hd, input logic [31:0] cv, input logic [3:0] cls,
            input logic start);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tdata <= {4'b0, cls, cv, hd, y, x};
        i_s_axis_tuser <= start;
        i_s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_vertex({4'b0, cls, cv, hd, y, x}, start);
        @(negedge i_clk);
    endtask

    // Wait for all points, then allow the block to finish any silent segment.
    task automatic drain;
        i_s_axis_tvalid <= 1'b0;
        while (pending_points.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    task automatic write_spacing(input logic [30:0] v);
        drain();
        i_cfg_wdata <= v;
        i_cfg_we <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        pr_spacing = v;
    endtask

    // Output sink: random stalls, or a long hold when asked.
    initial begin
        int w;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_m_axis_tready <= 1'b0;
                hold_cycles--;
            end else if (!sink_random) begin
                i_m_axis_tready <= 1'b1;
            end else if (i_m_axis_tready && !(o_m_axis_tvalid)) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                w = $urandom_range(0, 14);
                if (w > 0) begin
                    i_m_axis_tready <= 1'b0;
                    repeat (w) @(negedge i_clk);
                end
                i_m_axis_tready <= 1'b1;
                @(posedge i_clk);
                while (!o_m_axis_tvalid) @(posedge i_clk);
            end
        end
    end

    // Compare each accepted point with the oldest expectation.
    initial begin
        t_point want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                if (pending_points.size() == 0) begin
                    report_mismatch("unexpected point", o_m_axis_tdata[63:0], 0);
                end else begin
                    want = pending_points.pop_front();
                    if (o_m_axis_tdata[31:0] !== want.x)
                        report_mismatch("x", o_m_axis_tdata[31:0], want.x);
                    if (o_m_axis_tdata[63:32] !== want.y)
                        report_mismatch("y", o_m_axis_tdata[63:32], want.y);
                    if (o_m_axis_tdata[79:64] !== want.head)
                        report_mismatch("heading", o_m_axis_tdata[79:64], want.head);
                    if (o_m_axis_tdata[95:80] !== want.normal)
                        report_mismatch("normal", o_m_axis_tdata[95:80], want.normal);
                    if (o_m_axis_tdata[127:96] !== want.curv)
                        report_mismatch("curvature", o_m_axis_tdata[127:96], want.curv);
                    if (o_m_axis_tdata[131:128] !== want.cls)
                        report_mismatch("class", o_m_axis_tdata[131:128], want.cls);
                    if (o_m_axis_tlast !== want.last)
                        report_mismatch("last", o_m_axis_tlast, want.last);
                    if (o_m_axis_tuser !== want.ovf)
                        report_mismatch("overflow", o_m_axis_tuser, want.ovf);
                end
            end
        end
    end

    // Extremes of the fields, short and zero-length segments, and overflow.
    task automatic test_directed;
        send_vertex(32'sd0, 32'sd0, 16'hFFFF, 32'hFFFF_FFFF, 4'hF, 1'b0);
        send_vertex(32'sd0, 32'sd0, 16'h0, 32'h0, 4'h0, 1'b0);
        send_vertex(32'sd196608, 32'sd0, 16'h0, 32'h0, 4'h3, 1'b0);
        send_vertex(32'sd196608, 32'sd262144, 16'h0, 32'h0, 4'h5, 1'b0);
        send_vertex(32'sd0, 32'sd0, 16'h0, 32'h0, 4'h6, 1'b0);
        send_vertex(32'sd30000, 32'sd0, 16'h0, 32'h0, 4'h7, 1'b0);
        send_vertex(32'sd60000, 32'sd0, 16'h0, 32'h0, 4'h7, 1'b0);
        send_vertex(32'sd60000, -32'sd131072, 16'h0, 32'h0, 4'h8, 1'b0);
        send_vertex(-32'sd2147483648, 32'sd2147483647, 16'h8000, 32'h8000_0000,
                    4'hA, 1'b1);
        send_vertex(32'sd2147483647, -32'sd2147483648, 16'h7FFF, 32'h7FFF_FFFF,
                    4'h5, 1'b0);
        send_vertex(32'sd0, 32'sd0, 16'h1234, 32'h5555_AAAA, 4'h9, 1'b1);
        send_vertex(-32'sd65536, 32'sd65536, 16'h0, 32'h0, 4'h1, 1'b0);
        send_vertex(-32'sd65536, -32'sd65536, 16'h0, 32'h0, 4'h2, 1'b0);
        send_vertex(32'sd0, -32'sd65536, 16'h0, 32'h0, 4'h2, 1'b0);
    endtask

    // Spacing extremes and lowering spacing with a carry in hand.
    task automatic test_spacing_settings;
        write_spacing(31'd200000);
        send_vertex(32'sd0, 32'sd0, 16'h0, 32'h0, 4'h1, 1'b1);
        send_vertex(32'sd190000, 32'sd0, 16'h0, 32'h0, 4'h1, 1'b0);
        write_spacing(31'd1000);
        send_vertex(32'sd200000, 32'sd0, 16'h0, 32'h0, 4'h2, 1'b0);
        write_spacing(31'd0);
        send_vertex(32'sd200010, 32'sd0, 16'h0, 32'h0, 4'h2, 1'b0);
        write_spacing(31'h7FFF_FFFF);
        send_vertex(-32'sd2147483648, -32'sd2147483648, 16'h0, 32'h0, 4'h3, 1'b1);
        send_vertex(32'sd2147483647, 32'sd2147483647, 16'h0, 32'h0, 4'h3, 1'b0);
        write_spacing(31'd1);
        send_vertex(32'sd2147483647, 32'sd2147483600, 16'h0, 32'h0, 4'h4, 1'b0);
        write_spacing(31'd65536);
    endtask

    // Hold the output off while vertices keep coming, so input backs up.
    task automatic test_backpressure;
        hold_cycles = 1500;
        send_vertex(32'sd0, 32'sd0, 16'h0, 32'h0, 4'h1, 1'b1);
        for (int i = 1; i <= 8; i++)
            send_vertex(i * 32'sd200000, i * 32'sd70000, 16'h0, 32'h0, 4'(i), 1'b0);
    endtask

    // Random paths: mostly walks with modest steps, some wild jumps.
    task automatic test_random_paths;
        logic signed [31:0] x, y;
        int mode;
        x = 0;
        y = 0;
        for (int i = 0; i < 90; i++) begin
            if (i % 40 == 0)
                write_spacing($urandom_range(0, 3) == 0 ? 31'($urandom())
                              : 31'($urandom_range(4000, 300000)));
            mode = $urandom_range(0, 19);
            if (mode == 0) begin
                x = $urandom();
                y = $urandom();
            end else if (mode == 1) begin
                x = x;
            end else begin
                x = x + $signed($urandom_range(0, 600000)) - 300000;
                y = y + $signed($urandom_range(0, 600000)) - 300000;
            end
            send_vertex(x, y, 16'($urandom()), $urandom(), 4'($urandom()),
                        $urandom_range(0, 24) == 0);
        end
    endtask

    initial begin
        error_count = 0;
        hold_cycles = 0;
        sink_random = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = 1'b0;
        pr_spacing = SPACING_RST;
        pr_prev_x = 0; pr_prev_y = 0; pr_emit_x = 0; pr_emit_y = 0;
        pr_prev_cls = 0; pr_carry = 0; pr_started = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        sink_random = 1'b1;
        test_directed();
        test_spacing_settings();
        test_backpressure();
        test_random_paths();
        drain();
        if (error_count == 0)
            $display("tb_polyline_arc_length_resampler: clean");
        else
            $display("tb_polyline_arc_length_resampler: errors");
        $finish;
    end

    initial begin
        #100ms;
        $display("tb_polyline_arc_length_resampler: errors");
        $finish;
    end

endmodule
